@@ rtl/ber_real_to_double_decoder_unit_macros.svh @@
// Assertion macros for the BER REAL to double decoder.
// Used by the top level; expects clk and arst_n in scope.
`ifndef BER_REAL_TO_DOUBLE_DECODER_UNIT_MACROS_SVH
`define BER_REAL_TO_DOUBLE_DECODER_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define BER2D_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ber2d same-cycle check failed");

// next-cycle implication, off during reset
`define BER2D_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ber2d next-cycle check failed");

`endif

@@ rtl/ber2d_pkg.sv @@
// Shared types, codes and constants of the BER REAL to double decoder.
// No dependencies.
package ber2d_pkg;

	localparam int BER2D_MAX_CONTENT = 255;

	localparam logic [63:0] INF_BITS  = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;

	typedef enum logic [1:0] {
		ERR_OK      = 2'd0,
		ERR_INVALID = 2'd1,
		ERR_RANGE   = 2'd2,
		ERR_DECIMAL = 2'd3
	} err_t;

	typedef enum logic [5:0] {
		PH_HDR    = 6'b000001,
		PH_ELEN   = 6'b000010,
		PH_EXP    = 6'b000100,
		PH_MANT   = 6'b001000,
		PH_BIGEXP = 6'b010000,
		PH_HOLD   = 6'b100000
	} phase_t;

	// finished value leaving the parser
	typedef struct packed {
		logic               cvt;
		logic               sign;
		logic [63:0]        n;
		logic [2:0]         base_log;
		logic [1:0]         scale_f;
		logic signed [23:0] e;
		logic [7:0]         mant_octets;
		logic [63:0]        dval;
		err_t               derr;
	} job_t;

	// after scale and leading-one search
	typedef struct packed {
		logic               cvt;
		logic               zero;
		logic               sign;
		logic [63:0]        n;
		logic [5:0]         p;
		logic signed [27:0] scale;
		logic [63:0]        dval;
		err_t               derr;
	} lead_t;

	// after rounding to 53 bits
	typedef struct packed {
		logic               cvt;
		logic               zero;
		logic               sign;
		logic [52:0]        m;
		logic signed [28:0] ev;
		logic [63:0]        dval;
		err_t               derr;
	} pack_t;

endpackage

@@ rtl/ber2d_front.sv @@
// Octet parser: header, exponent and mantissa collection, special values.
// Depends on ber2d_pkg.
module ber2d_front import ber2d_pkg::*; #(
	parameter int MAX_CONTENT_OCTETS = BER2D_MAX_CONTENT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       en,
	input  logic [7:0] octet,
	input  logic       last,
	input  logic       empty_req,
	output logic       job_valid_s1,
	output job_t       job_s1
);

	localparam int CNT_W = $clog2(MAX_CONTENT_OCTETS + 2);
	localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_CONTENT_OCTETS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CONTENT_OCTETS);

	phase_t           phase_q, phase_n;
	logic             sign_q, sign_n;
	logic [2:0]       blog_q, blog_n;
	logic [1:0]       sf_q, sf_n;
	logic [7:0]       eoct_q, eoct_n;
	logic [7:0]       eseen_q, eseen_n;
	logic [23:0]      eacc_q, eacc_n;
	logic [63:0]      mant_q, mant_n;
	logic [7:0]       moct_q, moct_n;
	err_t             herr_q, herr_n;
	logic [63:0]      hval_q, hval_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	job_t             job;
	logic             done;

	assign done = accept && (last || empty_req);

	// next parser state for one word
	always_comb begin
		phase_n = phase_q; sign_n = sign_q; blog_n = blog_q; sf_n = sf_q;
		eoct_n = eoct_q; eseen_n = eseen_q; eacc_n = eacc_q;
		mant_n = mant_q; moct_n = moct_q; herr_n = herr_q; hval_n = hval_q;
		cnt_n = (cnt_q < CNT_SAT) ? cnt_q + 1'b1 : cnt_q;
		if (cnt_n > CNT_MAX) begin
			phase_n = PH_HOLD; herr_n = ERR_INVALID; hval_n = '0;
		end else begin
			unique case (phase_q)
				PH_HDR: begin
					if (octet[7]) begin
						sign_n = octet[6];
						sf_n = octet[3:2];
						eseen_n = '0;
						eacc_n = '0;
						if (octet[1:0] == 2'b11) begin
							phase_n = PH_ELEN;
						end else begin
							eoct_n = {6'd0, octet[1:0]} + 8'd1;
							phase_n = PH_EXP;
						end
						unique case (octet[5:4])
							2'b00: blog_n = 3'd1;
							2'b01: blog_n = 3'd3;
							2'b10: blog_n = 3'd4;
							default: begin
								phase_n = PH_HOLD; herr_n = ERR_INVALID; hval_n = '0;
							end
						endcase
					end else if (octet[6]) begin
						phase_n = PH_HOLD;
						herr_n = ERR_OK;
						unique case (octet[5:0])
							6'h00: hval_n = INF_BITS;
							6'h01: hval_n = {1'b1, INF_BITS[62:0]};
							6'h02: hval_n = QNAN_BITS;
							6'h03: hval_n = {1'b1, 63'd0};
							default: begin
								herr_n = ERR_INVALID; hval_n = '0;
							end
						endcase
					end else begin
						phase_n = PH_HOLD; herr_n = ERR_DECIMAL; hval_n = '0;
					end
				end
				PH_ELEN: begin
					eoct_n = octet;
					eseen_n = '0;
					if (octet == 8'd0) begin
						phase_n = PH_HOLD; herr_n = ERR_INVALID; hval_n = '0;
					end else if (octet >= 8'd3) begin
						phase_n = PH_BIGEXP; herr_n = ERR_RANGE; hval_n = '0;
					end else begin
						phase_n = PH_EXP;
					end
				end
				PH_EXP: begin
					eacc_n = {eacc_q[15:0], octet};
					eseen_n = eseen_q + 8'd1;
					if (eseen_n >= eoct_q) begin
						phase_n = PH_MANT; mant_n = '0; moct_n = '0;
					end
				end
				PH_MANT: begin
					if (moct_q < 8'd8) mant_n = {mant_q[55:0], octet};
					if (moct_q != 8'd255) moct_n = moct_q + 8'd1;
				end
				PH_BIGEXP: begin
					if (eseen_q == 8'd0) begin
						hval_n = octet[7] ? {sign_q, 63'd0} : {sign_q, INF_BITS[62:0]};
					end
					if (eseen_q != 8'd255) eseen_n = eseen_q + 8'd1;
				end
				PH_HOLD: begin
				end
				default: begin
				end
			endcase
		end
	end

	// build the finished word from the next state
	always_comb begin
		job = '0;
		job.sign = sign_n;
		job.n = mant_n;
		job.base_log = blog_n;
		job.scale_f = sf_n;
		job.mant_octets = moct_n;
		unique case (eoct_n)
			8'd1: job.e = {{16{eacc_n[7]}}, eacc_n[7:0]};
			8'd2: job.e = {{8{eacc_n[15]}}, eacc_n[15:0]};
			default: job.e = eacc_n;
		endcase
		job.dval = '0;
		job.derr = ERR_INVALID;
		if (empty_req) begin
			job.derr = ERR_OK;
		end else begin
			unique case (phase_n)
				PH_MANT: job.cvt = 1'b1;
				PH_BIGEXP: begin
					job.dval = (eseen_n >= eoct_n) ? hval_n : '0;
					job.derr = ERR_RANGE;
				end
				PH_HOLD: begin
					job.dval = hval_n;
					job.derr = herr_n;
				end
				default: begin
				end
			endcase
		end
	end

	// advance parser state; clear after each value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR; sign_q <= 1'b0; blog_q <= '0; sf_q <= '0;
			eoct_q <= '0; eseen_q <= '0; eacc_q <= '0; mant_q <= '0; moct_q <= '0;
			herr_q <= ERR_OK; hval_q <= '0; cnt_q <= '0;
		end else if (done) begin
			phase_q <= PH_HDR; sign_q <= 1'b0; blog_q <= '0; sf_q <= '0;
			eoct_q <= '0; eseen_q <= '0; eacc_q <= '0; mant_q <= '0; moct_q <= '0;
			herr_q <= ERR_OK; hval_q <= '0; cnt_q <= '0;
		end else if (accept) begin
			phase_q <= phase_n; sign_q <= sign_n; blog_q <= blog_n; sf_q <= sf_n;
			eoct_q <= eoct_n; eseen_q <= eseen_n; eacc_q <= eacc_n;
			mant_q <= mant_n; moct_q <= moct_n;
			herr_q <= herr_n; hval_q <= hval_n; cnt_q <= cnt_n;
		end
	end

	// hand the finished word to the converter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
		end else if (en) begin
			job_valid_s1 <= done;
		end
	end

	always_ff @(posedge clk) begin
		if (en) job_s1 <= job;
	end

endmodule

@@ rtl/ber2d_norm.sv @@
// Scale computation, leading-one search and rounding of N to 53 bits.
// Depends on ber2d_pkg.
module ber2d_norm import ber2d_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  job_valid_s1,
	input  job_t  job_s1,
	output logic  pk_valid_s3,
	output pack_t pk_s3
);

	lead_t              ld, ld_s2;
	logic               ld_valid_s2;
	pack_t              pk;
	logic [7:0]         excess;
	logic signed [27:0] ex;
	logic signed [27:0] prod;
	logic [3:0]         s;
	logic [63:0]        q, rem, half;
	logic               up;
	logic [53:0]        m54;
	logic [5:0]         lsh;
	logic signed [28:0] scale2;

	// scale and leading one
	always_comb begin
		excess = (job_s1.mant_octets > 8'd8) ? job_s1.mant_octets - 8'd8 : 8'd0;
		ex = 28'(job_s1.e);
		unique case (job_s1.base_log)
			3'd1: prod = ex;
			3'd3: prod = (ex <<< 1) + ex;
			default: prod = ex <<< 2;
		endcase
		ld.cvt = job_s1.cvt;
		ld.sign = job_s1.sign;
		ld.n = job_s1.n;
		ld.dval = job_s1.dval;
		ld.derr = job_s1.derr;
		ld.zero = (job_s1.n == 64'd0);
		ld.scale = prod + 28'(job_s1.scale_f) + 28'({excess, 3'b000});
		ld.p = '0;
		for (int i = 0; i < 64; i++) begin
			if (job_s1.n[i]) ld.p = 6'(i);
		end
	end

	// round or left-align to 53 bits
	always_comb begin
		s = '0; q = '0; rem = '0; half = '0; up = 1'b0; m54 = '0; lsh = '0;
		pk.cvt = ld_s2.cvt;
		pk.zero = ld_s2.zero;
		pk.sign = ld_s2.sign;
		pk.dval = ld_s2.dval;
		pk.derr = ld_s2.derr;
		if (ld_s2.p > 6'd52) begin
			s = 4'(ld_s2.p - 6'd52);
			q = ld_s2.n >> s;
			rem = ld_s2.n & ((64'd1 << s) - 64'd1);
			half = 64'd1 << (s - 4'd1);
			up = (rem > half) || ((rem == half) && q[0]);
			m54 = q[53:0] + 54'(up);
			if (m54[53]) begin
				pk.m = m54[53:1];
				scale2 = 29'(ld_s2.scale) + 29'(s) + 29'sd1;
			end else begin
				pk.m = m54[52:0];
				scale2 = 29'(ld_s2.scale) + 29'(s);
			end
		end else begin
			lsh = 6'd52 - ld_s2.p;
			pk.m = 53'(ld_s2.n << lsh);
			scale2 = 29'(ld_s2.scale) - 29'(lsh);
		end
		pk.ev = scale2 + 29'sd52;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_valid_s2 <= 1'b0;
			pk_valid_s3 <= 1'b0;
		end else if (en) begin
			ld_valid_s2 <= job_valid_s1;
			pk_valid_s3 <= ld_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ld_s2 <= ld;
			pk_s3 <= pk;
		end
	end

endmodule

@@ rtl/ber2d_pack.sv @@
// Range check, subnormal rounding and the result register.
// Depends on ber2d_pkg.
module ber2d_pack import ber2d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        pk_valid_s3,
	input  pack_t       pk_s3,
	output logic        res_valid_q,
	output logic [63:0] res_value_q,
	output err_t        res_err_q
);

	logic signed [29:0] r;
	logic [5:0]         rs;
	logic [52:0]        q, rem, half;
	logic               up;
	logic [63:0]        val;
	err_t               err;

	// encode the final double
	always_comb begin
		r = -30'sd1022 - 30'(pk_s3.ev);
		rs = r[5:0];
		q = '0; rem = '0; half = '0; up = 1'b0;
		val = '0;
		err = ERR_OK;
		if (!pk_s3.cvt) begin
			val = pk_s3.dval;
			err = pk_s3.derr;
		end else if (pk_s3.zero) begin
			val = {pk_s3.sign, 63'd0};
		end else if (pk_s3.ev > 29'sd1023) begin
			val = {pk_s3.sign, INF_BITS[62:0]};
			err = ERR_RANGE;
		end else if (pk_s3.ev >= -29'sd1022) begin
			val = {pk_s3.sign, 11'(pk_s3.ev + 29'sd1023), pk_s3.m[51:0]};
		end else if (r >= 30'sd54) begin
			val = {pk_s3.sign, 63'd0};
			err = ERR_RANGE;
		end else begin
			q = pk_s3.m >> rs;
			rem = pk_s3.m & ((53'd1 << rs) - 53'd1);
			half = 53'd1 << (rs - 6'd1);
			up = (rem > half) || ((rem == half) && q[0]);
			val = {pk_s3.sign, 10'd0, q + 53'(up)};
			if (rem != 53'd0) err = ERR_RANGE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= pk_valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_value_q <= val;
			res_err_q <= err;
		end
	end

endmodule

@@ rtl/ber_real_to_double_decoder_unit.sv @@
// Top level of the BER REAL contents to IEEE double decoder.
// Depends on ber2d_pkg, ber2d_front, ber2d_norm, ber2d_pack and the macro header.
//
//   channel | signals                                  | direction
//   input   | in_valid, in_ready, octet, last, empty_req | in
//   output  | out_valid, out_ready, value_bits, error_code | out
//
// One octet word is taken each cycle while the result side is not stalled.
// out_valid rises once the last octet has passed the parser register and
// three conversion stages (s2, s3 and the result register); the earliest
// hand-off is the edge after out_valid rises.
// All stages advance together; a held result stalls the whole pipe.
// Reset clears the parser phase and every stage valid.
`include "ber_real_to_double_decoder_unit_macros.svh"
module ber_real_to_double_decoder_unit import ber2d_pkg::*; #(
	parameter int MAX_CONTENT_OCTETS = BER2D_MAX_CONTENT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  octet,
	input  logic        last,
	input  logic        empty_req,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] value_bits,
	output logic [1:0]  error_code
);

	logic  en;
	logic  accept;
	logic  job_valid_s1;
	job_t  job_s1;
	logic  pk_valid_s3;
	pack_t pk_s3;
	err_t  res_err;

	// advance when the result register is free or being drained
	assign en = !out_valid || out_ready;
	assign in_ready = en;
	assign accept = in_valid && in_ready;
	assign error_code = res_err;

	ber2d_front #(
		.MAX_CONTENT_OCTETS(MAX_CONTENT_OCTETS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.en(en),
		.octet(octet),
		.last(last),
		.empty_req(empty_req),
		.job_valid_s1(job_valid_s1),
		.job_s1(job_s1)
	);

	ber2d_norm u_norm (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.job_valid_s1(job_valid_s1),
		.job_s1(job_s1),
		.pk_valid_s3(pk_valid_s3),
		.pk_s3(pk_s3)
	);

	ber2d_pack u_pack (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.pk_valid_s3(pk_valid_s3),
		.pk_s3(pk_s3),
		.res_valid_q(out_valid),
		.res_value_q(value_bits),
		.res_err_q(res_err)
	);

	`BER2D_ASSERT_NEXT(a_done_makes_job, accept && (last || empty_req), job_valid_s1)
	`BER2D_ASSERT_NEXT(a_no_job_without_last, accept && !last && !empty_req, !job_valid_s1)
	`BER2D_ASSERT_IMPL(a_decimal_zero, out_valid && error_code == ERR_DECIMAL, value_bits == 64'd0)
	`BER2D_ASSERT_IMPL(a_invalid_zero, out_valid && error_code == ERR_INVALID, value_bits == 64'd0)
	`BER2D_ASSERT_IMPL(a_range_no_nan,
		out_valid && error_code == ERR_RANGE && value_bits[62:52] == 11'h7FF,
		value_bits[51:0] == 52'd0)

endmodule

@@ tb/ber_real_to_double_decoder_unit_test.sv @@
// Self-checking testbench for the BER REAL contents to IEEE double decoder.
// Depends on ber2d_pkg and the ber_real_to_double_decoder_unit top level.
// It drives random and directed octet streams and predicts every result.
`timescale 1ns / 1ps
module ber_real_to_double_decoder_unit_test;
	import ber2d_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int FLUSH_CYCLES   = 20;
	localparam int HOLDOFF_CYCLES = 300;

	typedef struct {
		bit [7:0] octet;
		bit       last;
		bit       empty_req;
		bit       drain;
	} word_t;

	typedef struct {
		bit [63:0] value_bits;
		err_t      error_code;
	} result_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [7:0]  octet = 0;
	logic        last = 0;
	logic        empty_req = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [63:0] value_bits;
	logic [1:0]  error_code;

	word_t   words[$];
	word_t   cur_word;
	result_t expected_results[$];
	int      fails = 0;
	int      n_accepted = 0;
	int      stall_cnt = 0;
	int      holdoff_cnt = 0;
	bit      holdoff_done = 0;

	// decoder state mirror
	phase_t    st_phase;
	bit        st_sign;
	bit [2:0]  st_base_log;
	bit [1:0]  st_scale_f;
	bit [7:0]  st_exp_octets;
	bit [7:0]  st_exp_seen;
	bit [23:0] st_exp_acc;
	bit [63:0] st_mant;
	bit [7:0]  st_mant_octets;
	err_t      st_held_err;
	bit [63:0] st_held_val;
	int        st_count;

	ber_real_to_double_decoder_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.octet(octet), .last(last), .empty_req(empty_req),
		.out_valid(out_valid), .out_ready(out_ready),
		.value_bits(value_bits), .error_code(error_code)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void clear_decoder();
		st_phase = PH_HDR;
		st_sign = 0; st_base_log = 0; st_scale_f = 0;
		st_exp_octets = 0; st_exp_seen = 0; st_exp_acc = 0;
		st_mant = 0; st_mant_octets = 0;
		st_held_err = ERR_OK; st_held_val = 0;
		st_count = 0;
	endfunction

	function automatic void hold_result(err_t e, bit [63:0] v);
		st_phase = PH_HOLD;
		st_held_err = e;
		st_held_val = v;
	endfunction

	// shift right by s, round to nearest with ties to even
	function automatic bit [63:0] round_half_even(bit [63:0] m, int s, output bit inexact);
		bit [63:0] q, rem, half;
		q = m >> s;
		rem = m & ((64'd1 << s) - 1);
		half = 64'd1 << (s - 1);
		inexact = rem != 0;
		if (rem > half || (rem == half && q[0]))
			q++;
		return q;
	endfunction

	function automatic void to_double(output bit [63:0] val, output err_t err);
		bit [63:0] sgn, n, m, q;
		int bits, e, scale, ev, p, s, r;
		bit inexact;
		sgn = {st_sign, 63'd0};
		n = st_mant;
		bits = 8 * st_exp_octets;
		e = int'(st_exp_acc & ((24'd1 << bits) - 1));
		if (st_exp_acc[bits - 1])
			e -= (1 << bits);
		scale = int'(st_base_log) * e + int'(st_scale_f);
		if (st_mant_octets > 8)
			scale += 8 * (int'(st_mant_octets) - 8);
		err = ERR_OK;
		if (n == 0) begin
			val = sgn;
			return;
		end
		p = 63;
		while (!n[p])
			p--;
		if (p > 52) begin
			s = p - 52;
			m = round_half_even(n, s, inexact);
			if (m >> 53) begin
				m >>= 1;
				s++;
			end
			scale += s;
		end else begin
			m = n << (52 - p);
			scale -= 52 - p;
		end
		ev = scale + 52;
		if (ev > 1023) begin
			val = sgn | INF_BITS;
			err = ERR_RANGE;
			return;
		end
		if (ev >= -1022) begin
			val = sgn | (64'(ev + 1023) << 52) | (m & 64'h000F_FFFF_FFFF_FFFF);
			return;
		end
		// subnormal: round again
		r = -1022 - ev;
		if (r >= 54) begin
			q = 0;
			inexact = 1;
		end else begin
			q = round_half_even(m, r, inexact);
		end
		val = sgn | q;
		if (inexact)
			err = ERR_RANGE;
	endfunction

	function automatic void take_header(bit [7:0] o);
		if (o[7]) begin
			st_sign = o[6];
			case (o[5:4])
				2'b00: st_base_log = 1;
				2'b01: st_base_log = 3;
				2'b10: st_base_log = 4;
				default: begin
					hold_result(ERR_INVALID, 64'd0);
					return;
				end
			endcase
			st_scale_f = o[3:2];
			st_exp_seen = 0;
			st_exp_acc = 0;
			if (o[1:0] == 2'b11) begin
				st_phase = PH_ELEN;
			end else begin
				st_exp_octets = 8'(o[1:0]) + 8'd1;
				st_phase = PH_EXP;
			end
		end else if (o[6]) begin
			case (o[5:0])
				6'd0: hold_result(ERR_OK, INF_BITS);
				6'd1: hold_result(ERR_OK, {1'b1, 63'd0} | INF_BITS);
				6'd2: hold_result(ERR_OK, QNAN_BITS);
				6'd3: hold_result(ERR_OK, {1'b1, 63'd0});
				default: hold_result(ERR_INVALID, 64'd0);
			endcase
		end else begin
			hold_result(ERR_DECIMAL, 64'd0);
		end
	endfunction

	// advance the decoder by one accepted word, queue a result on the last one
	function automatic void decode_octet(word_t w);
		result_t res;
		if (w.empty_req) begin
			clear_decoder();
			res.value_bits = 0;
			res.error_code = ERR_OK;
			expected_results.push_back(res);
			return;
		end
		if (st_count < 511)
			st_count++;
		if (st_count > BER2D_MAX_CONTENT) begin
			hold_result(ERR_INVALID, 64'd0);
		end else begin
			case (st_phase)
				PH_HDR: take_header(w.octet);
				PH_ELEN: begin
					st_exp_octets = w.octet;
					st_exp_seen = 0;
					if (w.octet == 0) begin
						hold_result(ERR_INVALID, 64'd0);
					end else if (w.octet >= 3) begin
						st_phase = PH_BIGEXP;
						st_held_err = ERR_RANGE;
						st_held_val = 0;
					end else begin
						st_phase = PH_EXP;
					end
				end
				PH_EXP: begin
					st_exp_acc = {st_exp_acc[15:0], w.octet};
					st_exp_seen++;
					if (st_exp_seen >= st_exp_octets) begin
						st_phase = PH_MANT;
						st_mant = 0;
						st_mant_octets = 0;
					end
				end
				PH_MANT: begin
					if (st_mant_octets < 8)
						st_mant = {st_mant[55:0], w.octet};
					if (st_mant_octets < 255)
						st_mant_octets++;
				end
				PH_BIGEXP: begin
					if (st_exp_seen == 0)
						st_held_val = w.octet[7] ? {st_sign, 63'd0}
							: ({st_sign, 63'd0} | INF_BITS);
					if (st_exp_seen < 255)
						st_exp_seen++;
				end
				default: ;
			endcase
		end
		if (!w.last)
			return;
		case (st_phase)
			PH_MANT: to_double(res.value_bits, res.error_code);
			PH_BIGEXP: begin
				res.value_bits = (st_exp_seen >= st_exp_octets) ? st_held_val : 64'd0;
				res.error_code = ERR_RANGE;
			end
			PH_HOLD: begin
				res.value_bits = st_held_val;
				res.error_code = st_held_err;
			end
			default: begin
				res.value_bits = 0;
				res.error_code = ERR_INVALID;
			end
		endcase
		clear_decoder();
		expected_results.push_back(res);
	endfunction

	function automatic bit calm_stretch();
		return n_accepted >= 900 && n_accepted < 1200;
	endfunction

	// sender: present words, predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		word_t nxt;
		bit    have;
		if (!arst_n) begin
			in_valid <= 0;
			clear_decoder();
		end else begin
			if (in_valid && in_ready) begin
				decode_octet(cur_word);
				n_accepted++;
			end
			if (!in_valid || in_ready) begin
				have = 0;
				// pause point: wait until all results are in
				if (words.size() != 0 && words[0].drain && expected_results.size() == 0)
					void'(words.pop_front());
				if (words.size() != 0 && !words[0].drain
						&& (calm_stretch() || $urandom_range(99) >= 34)) begin
					nxt = words.pop_front();
					have = 1;
				end
				if (have) begin
					cur_word <= nxt;
					octet <= nxt.octet;
					last <= nxt.last;
					empty_req <= nxt.empty_req;
				end
				in_valid <= have;
			end
		end
	end

	// receiver: random stalls, one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
		end else if (!holdoff_done && n_accepted >= 500) begin
			holdoff_cnt++;
			if (holdoff_cnt >= HOLDOFF_CYCLES)
				holdoff_done = 1;
			out_ready <= 0;
		end else begin
			out_ready <= calm_stretch() || $urandom_range(99) >= 34;
		end
	end

	// check each result against the oldest expectation
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result value_bits=%h error_code=%0d", value_bits, error_code);
				fails++;
			end else begin
				exp_r = expected_results.pop_front();
				if (value_bits !== exp_r.value_bits) begin
					$error("value_bits expected %h actual %h", exp_r.value_bits, value_bits);
					fails++;
				end
				if (error_code !== exp_r.error_code) begin
					$error("error_code expected %0d actual %0d", exp_r.error_code, error_code);
					fails++;
				end
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cnt = 0;
		else
			stall_cnt++;
		if (stall_cnt >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic add_word(bit [7:0] o, bit l, bit e = 0);
		word_t w;
		w.octet = o;
		w.last = l;
		w.empty_req = e;
		w.drain = 0;
		words.push_back(w);
	endtask

	task automatic add_drain();
		word_t w;
		w = '{default: 0};
		w.drain = 1;
		words.push_back(w);
	endtask

	task automatic add_octets(bit [7:0] bytes[$]);
		foreach (bytes[i])
			add_word(bytes[i], i == bytes.size() - 1);
	endtask

	// one binary-form value with random content
	task automatic add_binary();
		bit [7:0] seq[$];
		int ef, n_mant;
		ef = $urandom_range(3);
		seq.push_back({1'b1, 1'($urandom), ($urandom_range(19) == 0) ? 2'b11
			: 2'($urandom_range(2)), 2'($urandom), 2'(ef)});
		if (ef == 3) begin
			ef = $urandom_range(5);
			seq.push_back(8'(ef));
		end else begin
			ef++;
		end
		for (int i = 0; i < ef; i++)
			seq.push_back((i == 0 && $urandom_range(1)) ? 8'($urandom_range(3))
				: 8'($urandom));
		n_mant = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(8);
		for (int i = 0; i < n_mant; i++)
			seq.push_back(8'($urandom));
		// truncate now and then
		if ($urandom_range(11) == 0)
			seq = seq[0:$urandom_range(seq.size() - 1)];
		add_octets(seq);
	endtask

	initial begin
		int pick;
		// directed: empty, specials, decimal, reserved base, truncations
		add_word(8'($urandom), 1'($urandom), 1);
		add_octets('{8'h40});
		add_octets('{8'h41});
		add_octets('{8'h42});
		add_octets('{8'h43});
		add_octets('{8'h7F, 8'hFF, 8'h00});
		add_octets('{8'h03, 8'h31});
		add_octets('{8'hB0, 8'hFF});
		add_octets('{8'h80});
		add_octets('{8'h83});
		add_octets('{8'h83, 8'h00, 8'h01});
		add_octets('{8'hC3, 8'h03, 8'h80, 8'h00, 8'h00, 8'h01});
		add_octets('{8'h83, 8'h03, 8'h7F, 8'hFF, 8'hFF});
		add_octets('{8'h83, 8'h04, 8'h01});
		add_octets('{8'h80, 8'h05});
		add_octets('{8'hC0, 8'h05, 8'h00, 8'h00});
		add_octets('{8'h81, 8'h7F, 8'hFF, 8'hFF});
		add_octets('{8'hA1, 8'h80, 8'h00, 8'h01});
		add_octets('{8'hEE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'hFF, 8'hFF});
		add_word(8'h80, 0);
		add_word(8'h01, 0);
		add_word(8'h00, 1'($urandom), 1);
		// too many octets before last
		add_word(8'h80, 0);
		add_word(8'h00, 0);
		for (int i = 0; i < 256; i++)
			add_word(8'($urandom), i == 255);
		add_drain();
		// random part: mostly well-formed values, some noise
		while (words.size() < 1950) begin
			pick = $urandom_range(99);
			if (pick < 75)
				add_binary();
			else if (pick < 83)
				add_octets('{{2'b01, 6'($urandom_range(5))}});
			else if (pick < 88)
				add_word(8'($urandom), 1'($urandom), 1);
			else if (pick < 92)
				add_octets('{{2'b00, 6'($urandom)}, 8'($urandom)});
			else
				add_word(8'($urandom), 1'($urandom));
			if (words.size() > 1000 && words.size() < 1010)
				add_drain();
		end
		add_word(8'h00, 1, 1);
		repeat (5) @(posedge clk);
		arst_n <= 1;
		wait (words.size() == 0 && !in_valid && expected_results.size() == 0);
		repeat (FLUSH_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/ber2d_pkg.sv
rtl/ber2d_front.sv
rtl/ber2d_norm.sv
rtl/ber2d_pack.sv
rtl/ber_real_to_double_decoder_unit.sv
tb/ber_real_to_double_decoder_unit_test.sv
